@@ rtl/hms_pkg.sv @@
// Package: opcodes, time and character types, and digit helpers for the clock counter.
package hms_pkg;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_SET   = 2'd1,
      OP_TICK  = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   localparam logic [5:0] SEC_LIMIT    = 6'd60;
   localparam logic [6:0] MIN_LIMIT    = 7'd60;
   localparam logic [6:0] HOUR_LAST    = 7'd99;
   localparam logic [3:0] DIGIT_MAX    = 4'd9;
   localparam logic [5:0] ASCII_ZERO   = 6'd48;
   localparam logic [7:0] DIV10_MULT   = 8'd205;
   localparam int         DIV10_SHIFT  = 11;

   typedef struct packed {
      logic [6:0] hours;
      logic [6:0] minutes;
      logic [5:0] seconds;
   } time_type;

   typedef struct packed {
      logic [5:0] hour_tens;
      logic [5:0] hour_ones;
      logic [5:0] minute_tens;
      logic [5:0] minute_ones;
      logic [5:0] second_tens;
      logic [5:0] second_ones;
   } chars_type;

   function automatic logic [3:0] digit_clamp(input logic [3:0] d);
      return (d > DIGIT_MAX) ? DIGIT_MAX : d;
   endfunction

   function automatic logic [6:0] digits_to_value(input logic [3:0] tens,
                                                  input logic [3:0] ones);
      logic [3:0] t;
      logic [3:0] o;
      t = digit_clamp(tens);
      o = digit_clamp(ones);
      return {t, 3'b000} + {2'b00, t, 1'b0} + {3'b000, o};
   endfunction

   // Reciprocal multiply; exact for every 7-bit value.
   function automatic logic [3:0] div10(input logic [6:0] v);
      logic [14:0] prod;
      prod = {8'd0, v} * {7'd0, DIV10_MULT};
      return prod[14:DIV10_SHIFT];
   endfunction

   function automatic logic [3:0] mod10(input logic [6:0] v);
      logic [3:0] q;
      logic [6:0] r;
      q = div10(v);
      r = v - {q, 3'b000} - {2'b00, q, 1'b0};
      return r[3:0];
   endfunction

   function automatic logic [5:0] to_ascii(input logic [3:0] d);
      return ASCII_ZERO + {2'b00, d};
   endfunction

endpackage

@@ rtl/hms_req_if.sv @@
// Interface: request channel carrying opcode and set digits.
interface hms_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [3:0] hour_tens;
   logic [3:0] hour_ones;
   logic [3:0] minute_tens;
   logic [3:0] minute_ones;

   modport source (output valid, opcode, hour_tens, hour_ones, minute_tens, minute_ones,
                   input ready);
   modport sink   (input valid, opcode, hour_tens, hour_ones, minute_tens, minute_ones,
                   output ready);
endinterface

@@ rtl/hms_rsp_if.sv @@
// Interface: response channel carrying the time and its ASCII digits.
interface hms_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] hours_now;
   logic [6:0] minutes_now;
   logic [5:0] seconds_now;
   logic [5:0] hour_tens_char;
   logic [5:0] hour_ones_char;
   logic [5:0] minute_tens_char;
   logic [5:0] minute_ones_char;
   logic [5:0] second_tens_char;
   logic [5:0] second_ones_char;

   modport source (output valid, hours_now, minutes_now, seconds_now, hour_tens_char,
                   hour_ones_char, minute_tens_char, minute_ones_char, second_tens_char,
                   second_ones_char, input ready);
   modport sink   (input valid, hours_now, minutes_now, seconds_now, hour_tens_char,
                   hour_ones_char, minute_tens_char, minute_ones_char, second_tens_char,
                   second_ones_char, output ready);
endinterface

@@ rtl/hms_clock_counter_top.sv @@
// Top level of the hours / minutes / seconds clock counter.
//
// Request channel (req_port): opcode clear, set hours and minutes from four
// decimal digits, one-second tick, or read. Every request transaction returns
// exactly one response transaction on rsp_port with the time after the step
// and its six ASCII digit characters.
// The response is registered: valid in the cycle after the request is taken.
// Throughput: one transaction per cycle while not stalled; the counter update
// and the digit split fit between the request edge and the response register.
// A new request is taken whenever the response register is empty or is
// being emptied in the same cycle, so a stalled receiver holds the response
// and back-pressures the request side only while it is full.
// Reset (synchronous, active high) clears the time to 00:00:00 and empties
// the response register.
module hms_clock_counter_top (
   input logic       clock,
   input logic       reset,
   hms_req_if.sink   req_port,
   hms_rsp_if.source rsp_port
);

   logic               accept;
   logic               rsp_free;
   hms_pkg::time_type  time_next;
   hms_pkg::chars_type chars_next;
   hms_pkg::time_type  time_out;
   hms_pkg::chars_type chars_out;

   assign req_port.ready = rsp_free;
   assign accept         = req_port.valid && rsp_free;

   hms_count u_count (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .opcode      (req_port.opcode),
      .hour_tens   (req_port.hour_tens),
      .hour_ones   (req_port.hour_ones),
      .minute_tens (req_port.minute_tens),
      .minute_ones (req_port.minute_ones),
      .time_next   (time_next)
   );

   hms_fmt u_fmt (
      .time_val (time_next),
      .chars    (chars_next)
   );

   hms_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .time_val  (time_next),
      .chars     (chars_next),
      .rsp_ready (rsp_port.ready),
      .rsp_valid (rsp_port.valid),
      .free      (rsp_free),
      .time_out  (time_out),
      .chars_out (chars_out)
   );

   assign rsp_port.hours_now        = time_out.hours;
   assign rsp_port.minutes_now      = time_out.minutes;
   assign rsp_port.seconds_now      = time_out.seconds;
   assign rsp_port.hour_tens_char   = chars_out.hour_tens;
   assign rsp_port.hour_ones_char   = chars_out.hour_ones;
   assign rsp_port.minute_tens_char = chars_out.minute_tens;
   assign rsp_port.minute_ones_char = chars_out.minute_ones;
   assign rsp_port.second_tens_char = chars_out.second_tens;
   assign rsp_port.second_ones_char = chars_out.second_ones;

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_port.valid)
      else $error("accepted request produced no response");

   a_seconds_range: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid |-> (rsp_port.seconds_now < hms_pkg::SEC_LIMIT))
      else $error("seconds out of range");

   a_hours_range: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid |-> (rsp_port.hours_now <= hms_pkg::HOUR_LAST))
      else $error("hours out of range");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_port.opcode == hms_pkg::OP_CLEAR)) |=>
         (rsp_port.hours_now == 7'd0 && rsp_port.minutes_now == 7'd0
          && rsp_port.seconds_now == 6'd0))
      else $error("clear did not zero the time");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && !rsp_port.ready) |=> $stable(time_out))
      else $error("stalled response changed");

endmodule

@@ rtl/hms_count.sv @@
// Time counter: holds hours, minutes, seconds and computes the next time per opcode.
module hms_count (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [1:0]        opcode,
   input  logic [3:0]        hour_tens,
   input  logic [3:0]        hour_ones,
   input  logic [3:0]        minute_tens,
   input  logic [3:0]        minute_ones,
   output hms_pkg::time_type time_next
);

   hms_pkg::time_type time_ff;
   hms_pkg::time_type time_in;
   logic [5:0]        sec_inc;
   logic [6:0]        min_step;

   always_comb begin
      time_in  = time_ff;
      sec_inc  = time_ff.seconds + 6'd1;
      min_step = time_ff.minutes;
      case (hms_pkg::op_type'(opcode))
         hms_pkg::OP_CLEAR: begin
            time_in = '0;
         end
         hms_pkg::OP_SET: begin
            time_in.hours   = hms_pkg::digits_to_value(hour_tens, hour_ones);
            time_in.minutes = hms_pkg::digits_to_value(minute_tens, minute_ones);
            time_in.seconds = '0;
         end
         hms_pkg::OP_TICK: begin
            if (sec_inc >= hms_pkg::SEC_LIMIT) begin
               time_in.seconds = '0;
               min_step        = time_ff.minutes + 7'd1;
            end else begin
               time_in.seconds = sec_inc;
            end
            if (min_step >= hms_pkg::MIN_LIMIT) begin
               time_in.minutes = '0;
               time_in.hours   = (time_ff.hours >= hms_pkg::HOUR_LAST) ? 7'd0
                                                                     : time_ff.hours + 7'd1;
            end else begin
               time_in.minutes = min_step;
            end
         end
         default: begin
            time_in = time_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
      end else if (accept) begin
         time_ff <= time_in;
      end
   end

   assign time_next = time_in;

endmodule

@@ rtl/hms_fmt.sv @@
// Formatter: splits the time into decimal digits and maps them to ASCII.
module hms_fmt (
   input  hms_pkg::time_type  time_val,
   output hms_pkg::chars_type chars
);

   logic [6:0] sec_wide;

   assign sec_wide = {1'b0, time_val.seconds};

   always_comb begin
      chars.hour_tens   = hms_pkg::to_ascii(hms_pkg::div10(time_val.hours));
      chars.hour_ones   = hms_pkg::to_ascii(hms_pkg::mod10(time_val.hours));
      chars.minute_tens = hms_pkg::to_ascii(hms_pkg::div10(time_val.minutes));
      chars.minute_ones = hms_pkg::to_ascii(hms_pkg::mod10(time_val.minutes));
      chars.second_tens = hms_pkg::to_ascii(hms_pkg::div10(sec_wide));
      chars.second_ones = hms_pkg::to_ascii(hms_pkg::mod10(sec_wide));
   end

endmodule

@@ rtl/hms_rsp_reg.sv @@
// Response register: holds one transaction until the receiver takes it.
module hms_rsp_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  hms_pkg::time_type  time_val,
   input  hms_pkg::chars_type chars,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic               free,
   output hms_pkg::time_type  time_out,
   output hms_pkg::chars_type chars_out
);

   logic               valid_ff;
   logic               valid_in;
   hms_pkg::time_type  time_ff;
   hms_pkg::chars_type chars_ff;

   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         time_ff  <= time_val;
         chars_ff <= chars;
      end
   end

   assign rsp_valid = valid_ff;
   assign time_out  = time_ff;
   assign chars_out = chars_ff;

endmodule
